/* rtl/core/siphash_pkg.sv */
// Shared types, constants and round functions for the SipHash-2-4 stream engine.
`timescale 1ns / 1ps

package siphash_pkg;

    localparam int WORD_W  = 64;
    localparam int COUNT_W = 4;
    localparam int LEN_W   = 8;
    localparam int TAIL_W  = 56;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    localparam logic [WORD_W-1:0] SIP_INIT_A = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SIP_INIT_B = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SIP_INIT_C = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SIP_INIT_D = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] SIP_FINAL_XOR = 64'h00000000000000ff;

    localparam logic [LEN_W-1:0] FULL_WORD_BYTES = 8'd8;

    // Register select: byte address bit 3 picks one of the two key halves.
    typedef enum logic {
        CFG_KEY_LOW  = 1'b0,
        CFG_KEY_HIGH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } sip_state_t;

    function automatic sip_state_t sip_round(input sip_state_t s);
        sip_state_t r;
        r = s;
        r.a = r.a + r.b;
        r.b = {r.b[50:0], r.b[63:51]};
        r.b = r.b ^ r.a;
        r.a = {r.a[31:0], r.a[63:32]};
        r.c = r.c + r.d;
        r.d = {r.d[47:0], r.d[63:48]};
        r.d = r.d ^ r.c;
        r.a = r.a + r.d;
        r.d = {r.d[42:0], r.d[63:43]};
        r.d = r.d ^ r.a;
        r.c = r.c + r.b;
        r.b = {r.b[46:0], r.b[63:47]};
        r.b = r.b ^ r.c;
        r.c = {r.c[31:0], r.c[63:32]};
        return r;
    endfunction

    function automatic sip_state_t sip_double_round(input sip_state_t s);
        return sip_round(sip_round(s));
    endfunction

    // One compression: mix the message word into d, two rounds, then into a.
    function automatic sip_state_t sip_absorb(input sip_state_t s,
                                              input logic [WORD_W-1:0] m);
        sip_state_t r;
        r = s;
        r.d = r.d ^ m;
        r = sip_double_round(r);
        r.a = r.a ^ m;
        return r;
    endfunction

    // Keeps the low count bytes of a word; counts of eight and up never reach here.
    function automatic logic [TAIL_W-1:0] keep_low_bytes(input logic [WORD_W-1:0] data,
                                                         input logic [2:0] count);
        logic [TAIL_W-1:0] r;
        r = '0;
        for (int i = 0; i < TAIL_W / 8; i++) begin
            if (3'(i) < count) begin
                r[8*i +: 8] = data[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/siphash_2_4_stream.sv */
// SipHash-2-4 stream engine: key registers, message compression and finalization pipeline.
`timescale 1ns / 1ps

// Usage: the key is written over the APB port (key_low at byte address 0,
// key_high at 8) while the engine is idle; it is sampled when a message starts.
// Message words arrive on the s_* stream, one little-endian 64-bit word per
// transaction, with the valid byte count in s_tdata[67:64] and s_tlast on the
// final word. Words that are not last are always taken as eight full bytes.
// One word is accepted every cycle while s_tready is high: the running state
// absorbs a word with two rounds as it is accepted. The last word enters a
// three-stage finalization pipeline (final block and 0xff step, two rounds,
// two rounds and digest); the digest passes the p1, p2, p3 and output
// registers to m_tdata, and a new message may start right behind a finished one.
// When the receiver stalls, results stay in the pipeline and the output
// register; s_tready drops only once every finalization stage and the output
// register are occupied and m_tready is low.
// Reset clears the key, the running state and all pipeline valid flags; the
// block accepts words as soon as reset is released.
module siphash_2_4_stream (
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [siphash_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [siphash_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [siphash_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready,
    // Message words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [siphash_pkg::S_TDATA_W-1:0]  s_tdata,  // data_word[63:0], byte_count[67:64]
    input  logic                               s_tlast,  // is_last
    // Digests
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [siphash_pkg::M_TDATA_W-1:0]  m_tdata   // digest[63:0]
);

    logic [siphash_pkg::WORD_W-1:0] key_low_reg,  key_low_next;
    logic [siphash_pkg::WORD_W-1:0] key_high_reg, key_high_next;

    siphash_pkg::sip_state_t         state_reg, state_next;
    logic [siphash_pkg::LEN_W-1:0]   length_reg, length_next;
    logic                            mid_message_reg, mid_message_next;

    siphash_pkg::sip_state_t         p1_state_reg, p1_state_next;
    logic [siphash_pkg::WORD_W-1:0]  p1_block_reg, p1_block_next;
    logic                            p1_valid_reg, p1_valid_next;
    siphash_pkg::sip_state_t         p2_state_reg, p2_state_next;
    logic                            p2_valid_reg, p2_valid_next;
    siphash_pkg::sip_state_t         p3_state_reg, p3_state_next;
    logic                            p3_valid_reg, p3_valid_next;
    logic [siphash_pkg::WORD_W-1:0]  digest_reg, digest_next;
    logic                            out_valid_reg, out_valid_next;

    logic                            cfg_write;
    logic                            s_fire;
    logic                            ready_out;
    logic                            ready_p3;
    logic                            ready_p2;
    logic                            ready_p1;

    logic [siphash_pkg::WORD_W-1:0]  data_word;
    logic [siphash_pkg::COUNT_W-1:0] byte_count;
    logic                            full_word;
    siphash_pkg::sip_state_t         start_state;
    siphash_pkg::sip_state_t         absorbed_state;
    logic [siphash_pkg::LEN_W-1:0]   length_base;
    logic [siphash_pkg::LEN_W-1:0]   length_sum;
    logic [siphash_pkg::TAIL_W-1:0]  tail_bytes;
    siphash_pkg::sip_state_t         p1_mixed;
    siphash_pkg::sip_state_t         p3_mixed;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        if (cfg_write)
        begin
            unique case (siphash_pkg::cfg_reg_t'(paddr[3]))
                siphash_pkg::CFG_KEY_LOW:  key_low_next  = pwdata;
                siphash_pkg::CFG_KEY_HIGH: key_high_next = pwdata;
                default:                   key_low_next  = key_low_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (siphash_pkg::cfg_reg_t'(paddr[3]))
            siphash_pkg::CFG_KEY_LOW:  prdata = key_low_reg;
            siphash_pkg::CFG_KEY_HIGH: prdata = key_high_reg;
            default:                   prdata = key_low_reg;
        endcase
    end

    // ---------------- handshakes ----------------
    // Each stage can take new data when it is empty or its content moves on.
    assign ready_out = !out_valid_reg || m_tready;
    assign ready_p3  = !p3_valid_reg || ready_out;
    assign ready_p2  = !p2_valid_reg || ready_p3;
    assign ready_p1  = !p1_valid_reg || ready_p2;
    assign s_tready  = ready_p1;
    assign s_fire    = s_tvalid && s_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = digest_reg;

    // ---------------- compression stage ----------------
    assign data_word  = s_tdata[siphash_pkg::WORD_W-1:0];
    assign byte_count = s_tdata[siphash_pkg::WORD_W +: siphash_pkg::COUNT_W];
    // A word that is not last, or a count of eight or more, is a full block.
    assign full_word  = !s_tlast || byte_count[3];

    always_comb
    begin
        if (mid_message_reg)
        begin
            start_state = state_reg;
            length_base = length_reg;
        end
        else
        begin
            start_state.a = siphash_pkg::SIP_INIT_A ^ key_low_reg;
            start_state.b = siphash_pkg::SIP_INIT_B ^ key_high_reg;
            start_state.c = siphash_pkg::SIP_INIT_C ^ key_low_reg;
            start_state.d = siphash_pkg::SIP_INIT_D ^ key_high_reg;
            length_base   = '0;
        end
    end

    assign absorbed_state = siphash_pkg::sip_absorb(start_state, data_word);
    assign length_sum     = length_base + (full_word ? siphash_pkg::FULL_WORD_BYTES
                                                     : {5'b0, byte_count[2:0]});
    assign tail_bytes     = full_word ? '0
                                      : siphash_pkg::keep_low_bytes(data_word, byte_count[2:0]);

    always_comb
    begin
        state_next       = state_reg;
        length_next      = length_reg;
        mid_message_next = mid_message_reg;
        p1_state_next    = p1_state_reg;
        p1_block_next    = p1_block_reg;
        if (s_fire)
        begin
            if (!s_tlast)
            begin
                state_next       = absorbed_state;
                length_next      = length_sum;
                mid_message_next = 1'b1;
            end
            else
            begin
                mid_message_next = 1'b0;
                p1_state_next    = full_word ? absorbed_state : start_state;
                p1_block_next    = {length_sum, tail_bytes};
            end
        end
    end

    // ---------------- finalization pipeline ----------------
    // The final block is absorbed and the 0xff step applied within the first stage.
    always_comb
    begin
        p1_mixed   = siphash_pkg::sip_absorb(p1_state_reg, p1_block_reg);
        p1_mixed.c = p1_mixed.c ^ siphash_pkg::SIP_FINAL_XOR;
        p3_mixed   = siphash_pkg::sip_double_round(p3_state_reg);
    end

    always_comb
    begin
        p1_valid_next  = p1_valid_reg;
        p2_valid_next  = p2_valid_reg;
        p3_valid_next  = p3_valid_reg;
        out_valid_next = out_valid_reg;
        p2_state_next  = p2_state_reg;
        p3_state_next  = p3_state_reg;
        digest_next    = digest_reg;

        if (ready_p1)
        begin
            p1_valid_next = s_fire && s_tlast;
        end
        if (ready_p2)
        begin
            p2_valid_next = p1_valid_reg;
            if (p1_valid_reg)
            begin
                p2_state_next = p1_mixed;
            end
        end
        if (ready_p3)
        begin
            p3_valid_next = p2_valid_reg;
            if (p2_valid_reg)
            begin
                p3_state_next = siphash_pkg::sip_double_round(p2_state_reg);
            end
        end
        if (ready_out)
        begin
            out_valid_next = p3_valid_reg;
            if (p3_valid_reg)
            begin
                digest_next = p3_mixed.a ^ p3_mixed.b ^ p3_mixed.c ^ p3_mixed.d;
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg     <= '0;
            key_high_reg    <= '0;
            state_reg       <= '0;
            length_reg      <= '0;
            mid_message_reg <= 1'b0;
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            p3_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            key_low_reg     <= key_low_next;
            key_high_reg    <= key_high_next;
            state_reg       <= state_next;
            length_reg      <= length_next;
            mid_message_reg <= mid_message_next;
            p1_valid_reg    <= p1_valid_next;
            p2_valid_reg    <= p2_valid_next;
            p3_valid_reg    <= p3_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_state_reg <= p1_state_next;
        p1_block_reg <= p1_block_next;
        p2_state_reg <= p2_state_next;
        p3_state_reg <= p3_state_next;
        digest_reg   <= digest_next;
    end

    // ---------------- assertions ----------------
    a_mid_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && !s_tlast |=> mid_message_reg)
        else $error("running state not kept after a non-final word");

    a_last_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_tlast |=> p1_valid_reg && !mid_message_reg)
        else $error("final word did not enter finalization");

    a_p1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg && !ready_p2 |=> p1_valid_reg && $stable(p1_block_reg))
        else $error("stalled finalization stage lost its block");

    a_p3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        p3_valid_reg && !ready_out |=> p3_valid_reg && $stable(p3_state_reg))
        else $error("stalled last stage lost its state");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg && p2_valid_reg && p3_valid_reg && out_valid_reg && !m_tready
        |-> !s_tready)
        else $error("word accepted while every stage is occupied");

endmodule
